FILE: hdl/tqpb_pkg.sv
// Package for the two-queue page buffer policy: status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tqpb_pkg;
  localparam int FRAMES_DEF = 16;
  localparam int PIN_W = 16;
  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_FREE      = 3'd1,
    ST_FIFO_EVICT = 3'd2,
    ST_LRU_EVICT = 3'd3,
    ST_ALL_PINNED = 3'd4,
    ST_UNFIX_OK  = 3'd5,
    ST_UNFIX_ERR = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_SCAN_F,
    S_SCAN_L,
    S_VREAD,
    S_DROP,
    S_FIND,
    S_SHIFT,
    S_PUSH,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/two_queue_page_buffer_policy.sv
// Top level of the two-queue (FIFO + LRU) page replacement policy.
// Depends on tqpb_pkg.
//
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      tdata {mark_dirty, page_id, kind}, tuser none
// m_axis   out  tvalid/tready      tdata {victim_dirty, victim_page_id,
//                                          victim_valid, frame_slot, status}
// cfg      in   cfg_we             cfg_data = frames_in_use
//
// A request moves one frame per cycle through the lookup, then does a
// queue scan, then one queue entry per cycle for the drop shift, all
// through a single compare unit.
// Reset (rst, synchronous) empties the queues and frees every frame.
// s_tready is low while a request is in progress or its result waits.
`timescale 1ns / 1ps
`default_nettype none
module two_queue_page_buffer_policy
  import tqpb_pkg::*;
#(
  parameter int FRAMES = tqpb_pkg::FRAMES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [71:0]  s_tdata,   // kind[0], page_id[64:1], mark_dirty[65]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [79:0]       m_tdata    // status[2:0], frame_slot[6:3],
                                       // victim_valid[7], victim_page_id[71:8],
                                       // victim_dirty[72]
);
  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);

  logic [63:0]      frame_page [FRAMES];
  logic [FRAMES-1:0] frame_valid;
  logic [PIN_W-1:0] pin_count [FRAMES];
  logic [FRAMES-1:0] frame_dirty;
  logic [FW-1:0]    fifo_order [FRAMES];
  logic [FW-1:0]    lru_order [FRAMES];
  logic [CW-1:0]    fifo_length, lru_length;
  logic [4:0]       frames_in_use;

  state_t state, state_next;
  logic [CW-1:0] idx;
  logic          kind_r, dirty_r;
  logic [63:0]   page_r;
  logic          hit;
  logic [FW-1:0] hit_f, free_f, tgt;
  logic          free_ok;
  logic [CW-1:0] used;
  logic          q_lru;      // queue being worked: 1 lru, 0 fifo
  logic [CW-1:0] pos;
  logic [2:0]    status_r;
  logic          vvalid_r, vdirty_r;
  logic [63:0]   vpage_r;
  logic          push_lru;   // after drop: 1 push to lru tail, 0 to fifo, with push_en
  logic          push_en;
  logic [CW-1:0] limit;

  always_comb begin
    limit = (frames_in_use == 5'd0) ? CW'(1) :
            ({27'd0, frames_in_use} > FRAMES) ? CW'(FRAMES) : CW'(frames_in_use);
  end

  wire [FW-1:0] idx_f = idx[FW-1:0];
  wire [FW-1:0] qent = q_lru ? lru_order[idx_f] : fifo_order[idx_f];
  wire [CW-1:0] qlen = q_lru ? lru_length : fifo_length;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (s_tvalid) state_next = S_LOOK;
      S_LOOK:   if (idx == CW'(FRAMES - 1)) state_next = S_DECIDE;
      S_DECIDE: begin
        if (kind_r) begin
          if (!hit || pin_count[hit_f] == '0) state_next = S_OUT;
          else state_next = S_FIND;
        end else if (hit) state_next = S_FIND;
        else if (used < limit && free_ok) state_next = S_PUSH;
        else state_next = S_SCAN_F;
      end
      S_SCAN_F, S_SCAN_L: begin
        if (idx < qlen && idx < CW'(FRAMES)) begin
          if (pin_count[qent] == '0) state_next = S_VREAD;
        end else if (!q_lru) state_next = S_SCAN_L;
        else state_next = S_OUT;
      end
      S_VREAD:  state_next = S_SHIFT;
      S_FIND: begin
        if (idx < qlen && idx < CW'(FRAMES)) begin
          if (qent == tgt) state_next = S_SHIFT;
        end else if (!(status_r == ST_HIT && q_lru)) begin
          state_next = (status_r == ST_HIT) ? S_PUSH : S_OUT;
        end
      end
      S_SHIFT:  if (!(idx + CW'(1) < qlen)) state_next = push_en ? S_PUSH : S_OUT;
      S_PUSH:   state_next = S_OUT;
      S_OUT:    if (m_tvalid && m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      frame_dirty <= '0;
      fifo_length <= '0;
      lru_length <= '0;
      frames_in_use <= 5'd16;
      m_tvalid <= 1'b0;
      for (int i = 0; i < FRAMES; i++) pin_count[i] <= '0;
    end else begin
      if (cfg_we) frames_in_use <= cfg_data;
      case (state)
        S_IDLE: if (s_tvalid) begin
          kind_r <= s_tdata[0];
          page_r <= s_tdata[64:1];
          dirty_r <= s_tdata[65];
          idx <= '0;
          hit <= 1'b0;
          free_ok <= 1'b0;
          used <= '0;
          vvalid_r <= 1'b0;
          vdirty_r <= 1'b0;
          vpage_r <= '0;
          push_en <= 1'b0;
        end
        S_LOOK: begin
          if (frame_valid[idx_f]) begin
            used <= used + CW'(1);
            if (frame_page[idx_f] == page_r && !hit) begin
              hit <= 1'b1;
              hit_f <= idx_f;
            end
          end else if (!free_ok) begin
            free_ok <= 1'b1;
            free_f <= idx_f;
          end
          idx <= idx + CW'(1);
        end
        S_DECIDE: begin
          idx <= '0;
          if (kind_r) begin
            if (!hit || pin_count[hit_f] == '0) begin
              status_r <= ST_UNFIX_ERR;
              tgt <= '0;
            end else begin
              pin_count[hit_f] <= pin_count[hit_f] - PIN_W'(1);
              frame_dirty[hit_f] <= dirty_r;
              status_r <= ST_UNFIX_OK;
              tgt <= hit_f;
              q_lru <= 1'b1;
              push_lru <= 1'b1;
            end
          end else if (hit) begin
            if (pin_count[hit_f] != PIN_MAX) pin_count[hit_f] <= pin_count[hit_f] + PIN_W'(1);
            status_r <= ST_HIT;
            tgt <= hit_f;
            q_lru <= 1'b1;
            push_lru <= 1'b1;
            push_en <= 1'b1;
          end else if (used < limit && free_ok) begin
            status_r <= ST_FREE;
            tgt <= free_f;
            push_lru <= 1'b0;
            push_en <= 1'b1;
          end else begin
            q_lru <= 1'b0;
            push_lru <= 1'b0;
            push_en <= 1'b1;
          end
        end
        S_SCAN_F, S_SCAN_L: begin
          if (idx < qlen && idx < CW'(FRAMES)) begin
            if (pin_count[qent] == '0) begin
              tgt <= qent;
              pos <= idx;
              status_r <= q_lru ? ST_LRU_EVICT : ST_FIFO_EVICT;
            end else idx <= idx + CW'(1);
          end else if (!q_lru) begin
            q_lru <= 1'b1;
            idx <= '0;
          end else begin
            status_r <= ST_ALL_PINNED;
            tgt <= '0;
          end
        end
        S_VREAD: begin
          vvalid_r <= 1'b1;
          vpage_r <= frame_page[tgt];
          vdirty_r <= frame_dirty[tgt];
          idx <= pos;
        end
        S_FIND: begin
          // look for tgt in the chosen queue; on a fix miss from lru, try fifo
          if (idx < qlen && idx < CW'(FRAMES)) begin
            if (qent != tgt) idx <= idx + CW'(1);
            else if (status_r == ST_UNFIX_OK) push_en <= 1'b1;
          end else if (status_r == ST_HIT && q_lru) begin
            q_lru <= 1'b0;
            idx <= '0;
          end
        end
        S_SHIFT: begin
          if (idx + CW'(1) < qlen) begin
            if (q_lru) lru_order[idx_f] <= lru_order[FW'(idx + CW'(1))];
            else fifo_order[idx_f] <= fifo_order[FW'(idx + CW'(1))];
            idx <= idx + CW'(1);
          end else begin
            if (q_lru) lru_length <= lru_length - CW'(1);
            else fifo_length <= fifo_length - CW'(1);
          end
        end
        S_PUSH: begin
          if (push_lru) begin
            if (lru_length < CW'(FRAMES)) begin
              lru_order[lru_length[FW-1:0]] <= tgt;
              lru_length <= lru_length + CW'(1);
            end
          end else begin
            if (fifo_length < CW'(FRAMES)) begin
              fifo_order[fifo_length[FW-1:0]] <= tgt;
              fifo_length <= fifo_length + CW'(1);
            end
            frame_valid[tgt] <= 1'b1;
            frame_page[tgt] <= page_r;
            pin_count[tgt] <= PIN_W'(1);
            frame_dirty[tgt] <= 1'b0;
          end
        end
        S_OUT: begin
          if (m_tvalid && m_tready) m_tvalid <= 1'b0;
          else m_tvalid <= 1'b1;
        end
        default: m_tvalid <= 1'b0;
      endcase
    end
  end

  assign m_tdata = {7'd0, vdirty_r, vpage_r, vvalid_r, 4'(tgt), status_r};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while result pending");
  a_len_fifo: assert property (@(posedge clk) disable iff (rst)
    fifo_length <= CW'(FRAMES)) else $error("fifo length overflow");
  a_len_lru: assert property (@(posedge clk) disable iff (rst)
    lru_length <= CW'(FRAMES)) else $error("lru length overflow");
  a_victim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (vvalid_r == (status_r == ST_FIFO_EVICT || status_r == ST_LRU_EVICT)))
    else $error("victim flag mismatch");
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for two_queue_page_buffer_policy: directed and random fix/unfix traffic
// checked beat by beat against an in-bench model of the two-queue replacement policy.
// Depends on tqpb_pkg and the block itself.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import tqpb_pkg::*;

  localparam int NF = 16;
  localparam int WATCHDOG = 20000;
  localparam logic KIND_FIX = 1'b0;
  localparam logic KIND_UNFIX = 1'b1;

  typedef struct packed {
    logic        vdirty;
    logic [63:0] vpage;
    logic        vvalid;
    logic [3:0]  slot;
    status_t     status;
  } reply_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [4:0] cfg_data = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [79:0] m_tdata;

  two_queue_page_buffer_policy uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // policy model state
  logic [63:0] pg [NF];
  logic        pv [NF];
  logic [15:0] pins [NF];
  logic        dty [NF];
  int          fq [$];
  int          lq [$];
  logic [4:0]  limit_reg;

  reply_t replies_due [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit stall_en = 1;
  logic [63:0] pool [8];

  task automatic report(input string what, input logic [79:0] got, input logic [79:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic void model_reset();
    for (int i = 0; i < NF; i++) begin
      pg[i] = '0; pv[i] = 0; pins[i] = 0; dty[i] = 0;
    end
    fq.delete(); lq.delete();
    limit_reg = 5'd16;
  endfunction

  function automatic int q_pos(ref int q[$], input int f);
    foreach (q[i]) if (q[i] == f) return i;
    return -1;
  endfunction

  function automatic int first_free_pin(ref int q[$]);
    foreach (q[i]) if (pins[q[i]] == 0) return i;
    return -1;
  endfunction

  function automatic reply_t replace_predict(logic kind, logic [63:0] page, logic md);
    reply_t r;
    int f, p, lim, used, tgt;
    r = '0;
    f = -1;
    for (int i = 0; i < NF; i++) if (f < 0 && pv[i] && pg[i] == page) f = i;
    if (kind == KIND_UNFIX) begin
      if (f < 0 || pins[f] == 0) r.status = ST_UNFIX_ERR;
      else begin
        pins[f]--; dty[f] = md;
        p = q_pos(lq, f);
        if (p >= 0) begin lq.delete(p); lq.insert(lq.size(), f); end
        r.status = ST_UNFIX_OK; r.slot = 4'(f);
      end
    end else if (f >= 0) begin
      if (pins[f] != 16'hFFFF) pins[f]++;
      p = q_pos(lq, f);
      if (p >= 0) lq.delete(p);
      else begin
        p = q_pos(fq, f);
        if (p >= 0) fq.delete(p);
      end
      lq.insert(lq.size(), f);
      r.status = ST_HIT; r.slot = 4'(f);
    end else begin
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > NF) lim = NF;
      used = 0;
      for (int i = 0; i < NF; i++) if (pv[i]) used++;
      tgt = -1;
      r.status = ST_ALL_PINNED;
      if (used < lim) begin
        for (int i = 0; i < NF; i++) if (tgt < 0 && !pv[i]) tgt = i;
        if (tgt >= 0) r.status = ST_FREE;
      end
      if (tgt < 0) begin
        p = first_free_pin(fq);
        if (p >= 0) begin
          tgt = fq[p]; fq.delete(p); r.status = ST_FIFO_EVICT;
        end else begin
          p = first_free_pin(lq);
          if (p >= 0) begin
            tgt = lq[p]; lq.delete(p); r.status = ST_LRU_EVICT;
          end
        end
        if (tgt >= 0) begin
          r.vvalid = 1; r.vpage = pg[tgt]; r.vdirty = dty[tgt];
        end
      end
      if (tgt >= 0) begin
        pv[tgt] = 1; pg[tgt] = page; pins[tgt] = 1; dty[tgt] = 0;
        fq.insert(fq.size(), tgt);
        r.slot = 4'(tgt);
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic kind, input logic [63:0] page, input logic md);
    s_tdata <= {6'd0, md, page, kind};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    replies_due.insert(replies_due.size(), replace_predict(kind, page, md));
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      reply_t want;
      reply_t got;
      got = m_tdata[72:0];
      if (replies_due.size() == 0) report("unexpected beat", m_tdata, '0);
      else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          report("status", 80'(got.status), 80'(want.status));
        if (got.slot !== want.slot) report("frame_slot", 80'(got.slot), 80'(want.slot));
        if (got.vvalid !== want.vvalid)
          report("victim_valid", 80'(got.vvalid), 80'(want.vvalid));
        if (got.vpage !== want.vpage)
          report("victim_page_id", 80'(got.vpage), 80'(want.vpage));
        if (got.vdirty !== want.vdirty)
          report("victim_dirty", 80'(got.vdirty), 80'(want.vdirty));
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) m_tready <= 0;
    else if (!stall_en) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    while (replies_due.size() != 0) @(negedge clk);
    s_tvalid <= 0;
    repeat (3 * NF + 20) @(negedge clk);
  endtask

  task automatic set_limit(input logic [4:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    limit_reg = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_page();
    return ($urandom_range(0, 15) == 0) ? rand64() : pool[$urandom_range(0, 7)];
  endfunction

  task automatic test_directed();
    send_request(KIND_UNFIX, 64'd5, 1);
    send_request(KIND_FIX, 64'd0, 0);
    send_request(KIND_FIX, '1, 0);
    send_request(KIND_FIX, 64'd0, 0);
    send_request(KIND_UNFIX, 64'd0, 1);
    send_request(KIND_UNFIX, 64'd0, 0);
    send_request(KIND_UNFIX, 64'd0, 1);
    send_request(KIND_UNFIX, 64'd0, 1);
    send_request(KIND_UNFIX, '1, 1);
    send_request(KIND_FIX, 64'hA5A5_5A5A_0F0F_F0F0, 0);
    set_limit(5'd2);
    send_request(KIND_FIX, 64'd7, 0);
    send_request(KIND_FIX, 64'd8, 0);
    send_request(KIND_UNFIX, 64'hA5A5_5A5A_0F0F_F0F0, 0);
    send_request(KIND_FIX, 64'd9, 0);
    set_limit(5'd0);
    send_request(KIND_FIX, 64'd10, 0);
    set_limit(5'd31);
    send_request(KIND_FIX, 64'd11, 0);
  endtask

  task automatic test_pin_saturation();
    set_limit(5'd16);
    send_request(KIND_FIX, 64'hDEAD, 0);
    repeat (3) send_request(KIND_FIX, 64'hDEAD, 0);
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      repeat (6) send_request(KIND_FIX, rand64(), 0);
    join
  endtask

  task automatic test_random(input int n);
    logic [4:0] lims [6] = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd8};
    int seg;
    seg = n / 6;
    for (int k = 0; k < 6; k++) begin
      set_limit(lims[k]);
      for (int i = 0; i < 8; i++) pool[i] = rand64();
      stall_en = (k != 2);
      for (int i = 0; i < seg; i++)
        send_request($urandom_range(0, 9) < 6 ? KIND_FIX : KIND_UNFIX,
                     pick_page(), 1'($urandom_range(0, 1)));
    end
    stall_en = 1;
  endtask

  initial begin
    model_reset();
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_directed();
    test_pin_saturation();
    test_backpressure();
    test_random(1620);
    drain();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
hdl/tqpb_pkg.sv
hdl/two_queue_page_buffer_policy.sv
tb/testbench.sv
